@@ rtl/sscg_pkg.sv @@
// types and constants shared by the settings commit gate
`default_nettype none

package sscg_pkg;

    typedef enum logic [1:0] {
        EV_TOUCH  = 2'd0,
        EV_CLEAR  = 2'd1,
        EV_GATE   = 2'd2,
        EV_RESULT = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_SOFT   = 2'd1,
        MODE_LAST   = 2'd2,
        MODE_FORCED = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        DEC_NONE        = 3'd0,
        DEC_DEFER_QUIET = 3'd1,
        DEC_DEFER_LOG   = 3'd2,
        DEC_WRITE       = 3'd3,
        DEC_WAKE_WRITE  = 3'd4
    } decision_t;

    // register index taken from paddr[2]
    typedef enum logic {
        REG_DEBOUNCE = 1'b0,
        REG_LIMIT    = 1'b1
    } reg_index_t;

    localparam logic [31:0] DEBOUNCE_RESET = 32'd3000000;
    localparam logic [3:0]  LIMIT_RESET    = 4'd3;
    localparam logic [3:0]  COUNT_MAX      = 4'd15;

    typedef struct packed {
        func_t       func;
        logic [31:0] now_time;
        mode_t       mode;
        logic        parked;
        logic        battery;
        logic        writable;
        logic        failed;
    } item_t;

    typedef struct packed {
        logic       pending;
        logic [3:0] failure_count;
        logic       deferral_reported;
    } flags_t;

    typedef struct packed {
        decision_t decision;
        logic      retry_pending;
        logic      pending;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/sscg_eval.sv @@
// event evaluation: decision logic and next state for one request
`default_nettype none

module sscg_eval
    import sscg_pkg::*;
#(
    parameter int TIME_BITS = 32
)(
    input  wire item_t                  item,
    input  wire flags_t                 flags,
    input  wire logic [TIME_BITS-1:0]   change_time,
    input  wire logic [31:0]            debounce_time,
    input  wire logic [3:0]             failure_limit,
    output flags_t                      flags_next,
    output logic [TIME_BITS-1:0]        change_time_next,
    output result_t                     result
);

    localparam int EXT_BITS = (TIME_BITS > 32) ? TIME_BITS : 32;

    logic [EXT_BITS-1:0]  now_ext;
    logic [EXT_BITS-1:0]  debounce_ext;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] debounce_t;
    logic [TIME_BITS-1:0] age;
    logic                 idle_hold;
    logic                 park_hold;
    logic                 battery_hold;
    logic [3:0]           count_inc;
    logic                 give_up;

    // time values live modulo 2^TIME_BITS
    assign now_ext      = EXT_BITS'(item.now_time);
    assign debounce_ext = EXT_BITS'(debounce_time);
    assign now_t        = now_ext[TIME_BITS-1:0];
    assign debounce_t   = debounce_ext[TIME_BITS-1:0];
    assign age          = now_t - change_time;

    assign idle_hold    = (item.mode == MODE_IDLE) && (age < debounce_t);
    assign park_hold    = ((item.mode == MODE_IDLE) || (item.mode == MODE_SOFT))
                          && item.parked;
    assign battery_hold = (item.mode != MODE_LAST) && !item.battery;

    assign count_inc = (flags.failure_count < COUNT_MAX) ?
                       flags.failure_count + 4'd1 : flags.failure_count;
    assign give_up   = (count_inc >= failure_limit);

    always_comb
    begin
        flags_next           = flags;
        change_time_next     = change_time;
        result.decision      = DEC_NONE;
        result.retry_pending = 1'b0;
        unique case (item.func)
            EV_TOUCH:
            begin
                flags_next.pending       = 1'b1;
                flags_next.failure_count = 4'd0;
                change_time_next         = now_t;
            end
            EV_CLEAR:
            begin
                flags_next.pending       = 1'b0;
                flags_next.failure_count = 4'd0;
            end
            EV_GATE:
            begin
                if (!flags.pending || idle_hold || park_hold)
                begin
                    result.decision = DEC_NONE;
                end
                else if (battery_hold)
                begin
                    if (flags.deferral_reported)
                    begin
                        result.decision = DEC_DEFER_QUIET;
                    end
                    else
                    begin
                        result.decision              = DEC_DEFER_LOG;
                        flags_next.deferral_reported = 1'b1;
                    end
                end
                else
                begin
                    flags_next.deferral_reported = 1'b0;
                    if (!item.writable)
                    begin
                        // no file to write: drop the change
                        flags_next.pending       = 1'b0;
                        flags_next.failure_count = 4'd0;
                    end
                    else
                    begin
                        result.decision = item.parked ? DEC_WAKE_WRITE : DEC_WRITE;
                    end
                end
            end
            EV_RESULT:
            begin
                if (!item.failed || give_up)
                begin
                    flags_next.pending       = 1'b0;
                    flags_next.failure_count = 4'd0;
                end
                else
                begin
                    flags_next.pending       = 1'b1;
                    flags_next.failure_count = count_inc;
                    change_time_next         = now_t;
                    result.retry_pending     = 1'b1;
                end
            end
            default:
            begin
                flags_next = flags;
            end
        endcase
        result.pending = flags_next.pending;
    end

endmodule

`default_nettype wire

@@ rtl/settings_save_commit_gate_core.sv @@
// top level of the settings commit gate: handshake, config registers, state
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_ready    func now_time commit_mode drive_parked
//                                               battery_good store_writable write_failed
//   output    out        out_valid / out_ready  decision retry_pending pending
//   config    in/out     psel penable pwrite    paddr pwdata prdata pready
//
// one request per cycle while the output is not stalled; a request is captured in an input register
// and its result is then registered in the output register
// the state update between the two registers is one subtract-compare and a 4-bit counter step
// reset clears state and both valid flags; config returns to its reset values
// a stalled output holds its result while the input register takes one more request
`default_nettype none

module settings_save_commit_gate_core
    import sscg_pkg::*;
#(
    parameter int TIME_BITS = 32
)(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  func,
    input  wire logic [31:0] now_time,
    input  wire logic [1:0]  commit_mode,
    input  wire logic        drive_parked,
    input  wire logic        battery_good,
    input  wire logic        store_writable,
    input  wire logic        write_failed,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       decision,
    output logic             retry_pending,
    output logic             pending,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [31:0]          debounce_reg;
    logic [3:0]           limit_reg;
    item_t                item_reg;
    logic                 item_valid_reg;
    flags_t               flags_reg;
    flags_t               flags_next;
    logic [TIME_BITS-1:0] change_time_reg;
    logic [TIME_BITS-1:0] change_time_next;
    result_t              result_reg;
    result_t              result_next;
    logic                 out_valid_reg;
    logic                 advance;
    logic                 cfg_write;
    reg_index_t           cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = reg_index_t'(paddr[2]);

    always_comb
    begin
        unique case (cfg_index)
            REG_DEBOUNCE: prdata = debounce_reg;
            REG_LIMIT:    prdata = {28'd0, limit_reg};
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
            limit_reg    <= LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE: debounce_reg <= pwdata;
                REG_LIMIT:    limit_reg    <= pwdata[3:0];
                default:      debounce_reg <= debounce_reg;
            endcase
        end
    end

    // the item register moves on whenever the output register is free or draining
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.func     <= func_t'(func);
            item_reg.now_time <= now_time;
            item_reg.mode     <= mode_t'(commit_mode);
            item_reg.parked   <= drive_parked;
            item_reg.battery  <= battery_good;
            item_reg.writable <= store_writable;
            item_reg.failed   <= write_failed;
        end
    end

    sscg_eval #(
        .TIME_BITS (TIME_BITS)
    ) u_eval (
        .item             (item_reg),
        .flags            (flags_reg),
        .change_time      (change_time_reg),
        .debounce_time    (debounce_reg),
        .failure_limit    (limit_reg),
        .flags_next       (flags_next),
        .change_time_next (change_time_next),
        .result           (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg       <= '0;
            change_time_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= item_valid_reg;
            if (item_valid_reg)
            begin
                flags_reg       <= flags_next;
                change_time_reg <= change_time_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && item_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign decision      = result_reg.decision;
    assign retry_pending = result_reg.retry_pending;
    assign pending       = result_reg.pending;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// self-checking testbench for the settings commit gate: random and directed requests
module testbench
    import sscg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_ITEMS = 230;
    localparam int PHASES      = 6;

    class commit_gate_scoreboard;
        logic [31:0] debounce_us;
        logic [3:0]  fail_limit;
        logic        pend;
        logic [31:0] stamp;
        logic [3:0]  fail_cnt;
        logic        deferral_noted;
        result_t     expected_q[$];
        int          errors;

        function new();
            debounce_us    = DEBOUNCE_RESET;
            fail_limit     = LIMIT_RESET;
            pend           = 1'b0;
            stamp          = '0;
            fail_cnt       = '0;
            deferral_noted = 1'b0;
            errors         = 0;
        endfunction

        function void set_register(reg_index_t idx, logic [31:0] value);
            if (idx == REG_DEBOUNCE)
                debounce_us = value;
            else
                fail_limit = value[3:0];
        endfunction

        function decision_t gate_decision(item_t req);
            logic [31:0] age;
            age = req.now_time - stamp;
            if (!pend)
                return DEC_NONE;
            if (req.mode == MODE_IDLE && age < debounce_us)
                return DEC_NONE;
            if ((req.mode == MODE_IDLE || req.mode == MODE_SOFT) && req.parked)
                return DEC_NONE;
            if (req.mode != MODE_LAST && !req.battery)
            begin
                // low battery is reported once, then deferred quietly
                if (deferral_noted)
                    return DEC_DEFER_QUIET;
                deferral_noted = 1'b1;
                return DEC_DEFER_LOG;
            end
            deferral_noted = 1'b0;
            if (!req.writable)
            begin
                pend     = 1'b0;
                fail_cnt = '0;
                return DEC_NONE;
            end
            return req.parked ? DEC_WAKE_WRITE : DEC_WRITE;
        endfunction

        function logic write_outcome(item_t req);
            if (!req.failed)
            begin
                pend     = 1'b0;
                fail_cnt = '0;
                return 1'b0;
            end
            if (fail_cnt != COUNT_MAX)
                fail_cnt++;
            if (fail_cnt >= fail_limit)
            begin
                pend     = 1'b0;
                fail_cnt = '0;
                return 1'b0;
            end
            pend  = 1'b1;
            stamp = req.now_time;
            return 1'b1;
        endfunction

        function void note_request(item_t req);
            result_t want;
            want.decision      = DEC_NONE;
            want.retry_pending = 1'b0;
            case (req.func)
                EV_TOUCH:
                begin
                    pend     = 1'b1;
                    stamp    = req.now_time;
                    fail_cnt = '0;
                end
                EV_CLEAR:
                begin
                    pend     = 1'b0;
                    fail_cnt = '0;
                end
                EV_GATE:
                    want.decision = gate_decision(req);
                default:
                    want.retry_pending = write_outcome(req);
            endcase
            want.pending = pend;
            expected_q.push_back(want);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                $error("result with no request outstanding: decision %0d retry_pending %0d %s %0d",
                       got.decision, got.retry_pending, "pending", got.pending);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.decision !== want.decision)
            begin
                $error("decision: expected %0d, got %0d", want.decision, got.decision);
                errors++;
            end
            if (got.retry_pending !== want.retry_pending)
            begin
                $error("retry_pending: expected %0d, got %0d",
                       want.retry_pending, got.retry_pending);
                errors++;
            end
            if (got.pending !== want.pending)
            begin
                $error("pending: expected %0d, got %0d", want.pending, got.pending);
                errors++;
            end
        endfunction

        function void flag_leftovers();
            if (expected_q.size() != 0)
            begin
                $error("%0d results never arrived", expected_q.size());
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  func;
    logic [31:0] now_time;
    logic [1:0]  commit_mode;
    logic        drive_parked;
    logic        battery_good;
    logic        store_writable;
    logic        write_failed;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  decision;
    logic        retry_pending;
    logic        pending;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    commit_gate_scoreboard board;
    logic        steady;
    logic [31:0] clock_us;
    int          cycle_count = 0;
    result_t     seen;

    settings_save_commit_gate_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .now_time       (now_time),
        .commit_mode    (commit_mode),
        .drive_parked   (drive_parked),
        .battery_good   (battery_good),
        .store_writable (store_writable),
        .write_failed   (write_failed),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .decision       (decision),
        .retry_pending  (retry_pending),
        .pending        (pending),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic bit take_break();
        return !steady && ($urandom_range(0, 99) < 21);
    endfunction

    // result side: random back-pressure, checked at the rising edge
    always @(negedge clk)
        if (rst_n)
            out_ready = !take_break();

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen.decision      = decision_t'(decision);
            seen.retry_pending = retry_pending;
            seen.pending       = pending;
            board.check_result(seen);
        end
    end

    task automatic send_request(input item_t req);
        while (take_break())
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid       = 1'b1;
        func           = req.func;
        now_time       = req.now_time;
        commit_mode    = req.mode;
        drive_parked   = req.parked;
        battery_good   = req.battery;
        store_writable = req.writable;
        write_failed   = req.failed;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_request(req);
        @(negedge clk);
    endtask

    task automatic send_fields(input func_t f, input logic [31:0] t, input mode_t m,
                               input logic parked, input logic battery,
                               input logic writable, input logic failed);
        item_t req;
        req.func     = f;
        req.now_time = t;
        req.mode     = m;
        req.parked   = parked;
        req.battery  = battery;
        req.writable = writable;
        req.failed   = failed;
        send_request(req);
    endtask

    task automatic write_register(input reg_index_t idx, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        board.set_register(idx, value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (board.expected_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // times cluster around the debounce boundary of the current change
    function automatic item_t random_request();
        item_t       req;
        int          pick;
        logic [31:0] step_max;
        step_max = (board.debounce_us >> 1) + 32'd16;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            req.func = EV_TOUCH;
        else if (pick < 28)
            req.func = EV_CLEAR;
        else if (pick < 73)
            req.func = EV_GATE;
        else
            req.func = EV_RESULT;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            clock_us = $urandom();
        else if (pick < 12)
            clock_us = board.stamp + board.debounce_us - 32'd1;
        else if (pick < 18)
            clock_us = board.stamp + board.debounce_us;
        else
            clock_us = clock_us + $urandom_range(0, step_max);
        req.now_time = clock_us;
        req.mode     = mode_t'(2'($urandom_range(0, 3)));
        req.parked   = $urandom_range(0, 99) < 30;
        req.battery  = $urandom_range(0, 99) < 80;
        req.writable = $urandom_range(0, 99) < 90;
        req.failed   = 1'($urandom_range(0, 1));
        return req;
    endfunction

    task automatic run_phase(input int count);
        int    sent;
        int    burst;
        item_t req;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                // run of failed writes to push the failure count up
                burst = $urandom_range(4, 16);
                repeat (burst)
                begin
                    req        = random_request();
                    req.func   = EV_RESULT;
                    req.failed = 1'b1;
                    send_request(req);
                    sent++;
                end
            end
            else
            begin
                send_request(random_request());
                sent++;
            end
        end
    endtask

    initial
    begin
        logic [31:0] debounce_set[PHASES];
        logic [3:0]  limit_set[PHASES];
        logic [31:0] base;
        int          ph;

        board          = new();
        steady         = 1'b0;
        clock_us       = '0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        func           = EV_TOUCH;
        now_time       = '0;
        commit_mode    = MODE_IDLE;
        drive_parked   = 1'b0;
        battery_good   = 1'b0;
        store_writable = 1'b0;
        write_failed   = 1'b0;
        out_ready      = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;

        debounce_set[0] = 32'd0;
        limit_set[0]    = 4'd1;
        debounce_set[1] = 32'hFFFF_FFFF;
        limit_set[1]    = 4'd15;
        debounce_set[2] = 32'd1000;
        limit_set[2]    = 4'd2;
        debounce_set[3] = $urandom();
        limit_set[3]    = 4'($urandom_range(1, 15));
        debounce_set[4] = 32'd50000;
        limit_set[4]    = 4'd15;
        debounce_set[5] = DEBOUNCE_RESET;
        limit_set[5]    = 4'd1;

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // directed part at the reset settings, change stamped just before the wrap
        base = 32'hFFFF_FF00;
        send_fields(EV_GATE,   32'd0,              MODE_IDLE,   0, 0, 0, 0);
        send_fields(EV_TOUCH,  base,               MODE_FORCED, 1, 1, 1, 1);
        send_fields(EV_GATE,   base + 32'd100,     MODE_IDLE,   0, 1, 1, 0);
        send_fields(EV_GATE,   base + 32'd2999999, MODE_IDLE,   0, 1, 1, 0);
        send_fields(EV_GATE,   base + 32'd3000000, MODE_IDLE,   0, 1, 1, 0);
        send_fields(EV_GATE,   base + 32'd3000000, MODE_IDLE,   1, 1, 1, 0);
        send_fields(EV_GATE,   base,               MODE_SOFT,   1, 1, 1, 0);
        send_fields(EV_GATE,   base,               MODE_FORCED, 1, 1, 1, 0);
        send_fields(EV_GATE,   base,               MODE_SOFT,   0, 0, 1, 0);
        send_fields(EV_GATE,   base,               MODE_FORCED, 0, 0, 1, 0);
        send_fields(EV_GATE,   base,               MODE_LAST,   1, 0, 1, 0);
        send_fields(EV_GATE,   base,               MODE_SOFT,   0, 0, 1, 0);
        send_fields(EV_RESULT, 32'd5,              MODE_IDLE,   0, 1, 1, 1);
        send_fields(EV_RESULT, 32'd6,              MODE_IDLE,   0, 1, 1, 1);
        send_fields(EV_RESULT, 32'd7,              MODE_IDLE,   0, 1, 1, 1);
        // failed write with nothing pending marks the record pending
        send_fields(EV_RESULT, 32'd8,              MODE_IDLE,   0, 1, 1, 1);
        send_fields(EV_RESULT, 32'd9,              MODE_SOFT,   1, 0, 0, 0);
        send_fields(EV_TOUCH,  32'hFFFF_FFFF,      MODE_IDLE,   0, 0, 0, 0);
        send_fields(EV_CLEAR,  32'hFFFF_FFFF,      MODE_FORCED, 1, 1, 1, 1);
        send_fields(EV_CLEAR,  32'd0,              MODE_LAST,   0, 0, 0, 0);
        send_fields(EV_TOUCH,  32'd0,              MODE_SOFT,   0, 1, 0, 1);
        send_fields(EV_GATE,   32'd1,              MODE_FORCED, 0, 1, 0, 0);
        send_fields(EV_GATE,   32'd2,              MODE_LAST,   1, 1, 1, 0);
        send_fields(EV_TOUCH,  32'hFFFF_FFFF,      MODE_FORCED, 1, 1, 1, 1);
        send_fields(EV_GATE,   32'hFFFF_FFFF,      MODE_LAST,   1, 0, 1, 1);
        wait_drained();

        for (ph = 0; ph < PHASES; ph++)
        begin
            write_register(REG_DEBOUNCE, debounce_set[ph]);
            write_register(REG_LIMIT, {28'd0, limit_set[ph]});
            clock_us = board.stamp;
            steady   = (ph == 2);
            run_phase(PHASE_ITEMS);
            wait_drained();
        end

        board.flag_leftovers();
        if (board.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
